// ===== rtl/core/scfl_pkg.sv =====
// Shared constants, types and a helper function of the size-class free-list allocator.
`default_nettype none
package scfl_pkg;

	// Geometry of the pools.
	localparam int NUM_CLASSES      = 7;
	localparam int BLOCKS_PER_CLASS = 128;
	localparam int MAX_BLOCK_BYTES  = 512;
	localparam int MIN_SHIFT        = 3;

	// Field and storage widths.
	localparam int OP_W     = 1;
	localparam int SIZE_W   = 10;
	localparam int CLS_W    = 3;
	localparam int IDX_W    = 7;
	localparam int LINK_W   = 8;
	localparam int USED_W   = 8;
	localparam int STATUS_W = 3;
	localparam int ADDR_W   = CLS_W + IDX_W;
	localparam int MEM_DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BLOCKS_PER_CLASS);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO      = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_NONE_OUT  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
		logic clear;
	} scfl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
	} scfl_sts_t;

	// Smallest class whose block holds the given size: ceil(log2(size)) - 3, never below zero.
	// One extra bit so that a result beyond the last class can be detected.
	function automatic logic [CLS_W:0] alloc_class(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] m;
		logic [CLS_W+1:0]  bitlen;
		m = size - SIZE_W'(1);
		bitlen = '0;
		for (int b = 0; b < SIZE_W; b++) begin
			if (m[b]) begin
				bitlen = (CLS_W + 2)'(b + 1);
			end
		end
		if (bitlen > (CLS_W + 2)'(MIN_SHIFT)) begin
			alloc_class = (CLS_W + 1)'(bitlen - (CLS_W + 2)'(MIN_SHIFT));
		end else begin
			alloc_class = '0;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scfl_req_if.sv =====
// Request channel interface of the allocator: valid, ready and the request payload.
`default_nettype none
interface scfl_req_if;
	import scfl_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [SIZE_W-1:0]   request_size;
	logic [CLS_W-1:0]    block_class;
	logic [IDX_W-1:0]    block_index;

	modport source (output valid, output opcode, output request_size,
		output block_class, output block_index, input ready);
	modport sink (input valid, input opcode, input request_size,
		input block_class, input block_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/scfl_rsp_if.sv =====
// Result channel interface of the allocator: valid, ready and the result payload.
`default_nettype none
interface scfl_rsp_if;
	import scfl_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CLS_W-1:0]    grant_class;
	logic [IDX_W-1:0]    grant_index;
	logic [USED_W-1:0]   used_after;

	modport source (output valid, output status, output grant_class,
		output grant_index, output used_after, input ready);
	modport sink (input valid, input status, input grant_class,
		input grant_index, input used_after, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/size_class_free_list_allocator.sv =====
// Top level of the size-class free-list allocator: controller and datapath.
// Usage:
// Requests arrive on req (valid/ready). An allocate (opcode 0) carries a byte size
// and is served from the class of the smallest power-of-two block of 8 to 512
// bytes that holds it; a free (opcode 1) carries a class and a block index.
// Every request gives exactly one result on rsp (valid/ready) with a status,
// the class and index of the block, and the blocks in use in that class after
// a grant, a free or an exhausted allocate. A request passes the shared lookup
// step, which reads the head and the link store, then the commit step, which
// writes back the head, count and link and loads the output register. A new
// request can be accepted in the commit step of the one before it.
// After reset the block sweeps all 896 entries of the link store, one entry per
// cycle; req.ready stays low during that time.
// A finished result waits in the output register while the next request is
// already accepted and looked up; its commit holds until rsp.ready frees the
// output register, and no further request is taken meanwhile.
`default_nettype none
module size_class_free_list_allocator (
	input  wire         clk,
	input  wire         arst_n,
	scfl_req_if.sink    req,
	scfl_rsp_if.source  rsp
);
	import scfl_pkg::*;

	scfl_cmd_t cmd;
	scfl_sts_t sts;

	// Sequencing.
	scfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Storage and decision logic.
	scfl_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (req.opcode),
		.request_size (req.request_size),
		.block_class  (req.block_class),
		.block_index  (req.block_index),
		.status       (rsp.status),
		.grant_class  (rsp.grant_class),
		.grant_index  (rsp.grant_index),
		.used_after   (rsp.used_after)
	);

endmodule
`default_nettype wire

// ===== rtl/core/scfl_ctrl.sv =====
// Controller state machine: link store clearing, request sequencing and result valid.
`default_nettype none
module scfl_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	output scfl_pkg::scfl_cmd_t   cmd,
	input  wire scfl_pkg::scfl_sts_t sts
);
	import scfl_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_commit;

	// The result register may be loaded when it is empty or being drained.
	assign can_commit = !out_valid_q || out_ready;

	// A new request enters when idle, or in the commit cycle that frees the datapath.
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_COMMIT) && can_commit);

	// Commands to the datapath.
	always_comb begin
		cmd        = '0;
		cmd.load   = in_valid && in_ready;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.commit = (state_q == ST_COMMIT) && can_commit;
		cmd.clear  = (state_q == ST_CLEAR);
	end

	assign out_valid = out_valid_q;

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (cmd.commit) begin
						state_q <= cmd.load ? ST_LOOKUP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// No request is taken while the link store is being initialized.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("request accepted during link store clearing");

	// Every accepted request goes to the lookup step next.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_LOOKUP))
		else $error("accepted request did not start a lookup");

	// A lookup is always followed by its commit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |=> (state_q == ST_COMMIT))
		else $error("lookup not followed by commit");

	// A new result only appears after a commit.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.commit))
		else $error("result valid without a commit");

endmodule
`default_nettype wire

// ===== rtl/core/scfl_datapath.sv =====
// Datapath: list heads, used counts, link store memory, request and result registers.
`default_nettype none
module scfl_datapath (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire scfl_pkg::scfl_cmd_t          cmd,
	output scfl_pkg::scfl_sts_t               sts,
	input  wire [scfl_pkg::OP_W-1:0]          opcode,
	input  wire [scfl_pkg::SIZE_W-1:0]        request_size,
	input  wire [scfl_pkg::CLS_W-1:0]         block_class,
	input  wire [scfl_pkg::IDX_W-1:0]         block_index,
	output logic [scfl_pkg::STATUS_W-1:0]     status,
	output logic [scfl_pkg::CLS_W-1:0]        grant_class,
	output logic [scfl_pkg::IDX_W-1:0]        grant_index,
	output logic [scfl_pkg::USED_W-1:0]       used_after
);
	import scfl_pkg::*;

	// Request registers.
	logic [OP_W-1:0]     op_q;
	logic [SIZE_W-1:0]   size_q;
	logic [CLS_W-1:0]    rcls_q;
	logic [IDX_W-1:0]    ridx_q;

	// Per-class state.
	logic [LINK_W-1:0]   head_q [NUM_CLASSES];
	logic [USED_W-1:0]   used_q [NUM_CLASSES];

	// Link store.
	logic [LINK_W-1:0]   link_mem [MEM_DEPTH];
	logic [LINK_W-1:0]   rd_data_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   wr_addr;
	logic [LINK_W-1:0]   wr_data;
	logic [ADDR_W-1:0]   rd_addr;

	// Clearing sweep counters.
	logic [CLS_W-1:0]    clr_cls_q;
	logic [IDX_W-1:0]    clr_idx_q;

	// Lookup decision and its pipeline register.
	logic [CLS_W:0]      alloc_cls;
	logic [CLS_W:0]      sel_cls;
	logic                cls_ok;
	logic [CLS_W-1:0]    sel_idx;
	logic [LINK_W-1:0]   head_rd;
	logic [USED_W-1:0]   used_rd;
	logic [STATUS_W-1:0] dec_status;
	logic [CLS_W-1:0]    dec_cls;
	logic [IDX_W-1:0]    dec_idx;
	logic [USED_W-1:0]   dec_used;
	logic                dec_pop;
	logic                dec_push;

	logic [STATUS_W-1:0] status_s1;
	logic [CLS_W-1:0]    cls_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [USED_W-1:0]   used_s1;
	logic [LINK_W-1:0]   head_s1;
	logic                pop_s1;
	logic                push_s1;

	// Capture an accepted request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			size_q <= request_size;
			rcls_q <= block_class;
			ridx_q <= block_index;
		end
	end

	// Select the class and read its head and used count.
	assign alloc_cls = alloc_class(size_q);
	assign sel_cls   = (op_q == OP_FREE) ? {1'b0, rcls_q} : alloc_cls;
	assign cls_ok    = (sel_cls < (CLS_W + 1)'(NUM_CLASSES));
	assign sel_idx   = cls_ok ? sel_cls[CLS_W-1:0] : '0;
	assign head_rd   = head_q[sel_idx];
	assign used_rd   = used_q[sel_idx];

	// Decide the outcome of the request.
	always_comb begin
		dec_status = STATUS_OK;
		dec_cls    = '0;
		dec_idx    = '0;
		dec_used   = '0;
		dec_pop    = 1'b0;
		dec_push   = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (size_q == '0) begin
				dec_status = STATUS_ZERO;
			end else if (size_q > SIZE_W'(MAX_BLOCK_BYTES) || !cls_ok) begin
				dec_status = STATUS_TOO_LARGE;
			end else if (head_rd >= NULL_LINK || used_rd >= USED_W'(BLOCKS_PER_CLASS)) begin
				dec_status = STATUS_EXHAUSTED;
				dec_cls    = sel_idx;
				dec_used   = used_rd;
			end else begin
				dec_cls  = sel_idx;
				dec_idx  = head_rd[IDX_W-1:0];
				dec_used = used_rd + USED_W'(1);
				dec_pop  = 1'b1;
			end
		end else begin
			dec_cls = rcls_q;
			dec_idx = ridx_q;
			if (!cls_ok || {1'b0, ridx_q} >= LINK_W'(BLOCKS_PER_CLASS) || used_rd == '0) begin
				dec_status = STATUS_NONE_OUT;
			end else begin
				dec_used = used_rd - USED_W'(1);
				dec_push = 1'b1;
			end
		end
	end

	// Register the decision for the commit step.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			status_s1 <= dec_status;
			cls_s1    <= dec_cls;
			idx_s1    <= dec_idx;
			used_s1   <= dec_used;
			head_s1   <= head_rd;
			pop_s1    <= dec_pop;
			push_s1   <= dec_push;
		end
	end

	// Link store ports: the clearing sweep or a pushed block writes, a lookup reads the head link.
	assign mem_we  = cmd.clear || (cmd.commit && push_s1);
	assign wr_addr = cmd.clear ? {clr_cls_q, clr_idx_q} : {cls_s1, idx_s1};
	assign wr_data = cmd.clear ? (LINK_W'(clr_idx_q) + LINK_W'(1)) : head_s1;
	assign rd_addr = {sel_idx, head_rd[IDX_W-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (cmd.lookup) begin
			rd_data_q <= link_mem[rd_addr];
		end
	end

	// Clearing sweep over every class and block.
	assign sts.clear_done = (clr_cls_q == CLS_W'(NUM_CLASSES - 1)) &&
		(clr_idx_q == IDX_W'(BLOCKS_PER_CLASS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cls_q <= '0;
			clr_idx_q <= '0;
		end else if (cmd.clear) begin
			if (clr_idx_q == IDX_W'(BLOCKS_PER_CLASS - 1)) begin
				clr_idx_q <= '0;
				clr_cls_q <= clr_cls_q + CLS_W'(1);
			end else begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
		end
	end

	// Head and used count update at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				used_q[c] <= '0;
			end
		end else if (cmd.commit) begin
			if (pop_s1) begin
				head_q[cls_s1] <= rd_data_q;
				used_q[cls_s1] <= used_s1;
			end else if (push_s1) begin
				head_q[cls_s1] <= LINK_W'(idx_s1);
				used_q[cls_s1] <= used_s1;
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= status_s1;
			grant_class <= cls_s1;
			grant_index <= idx_s1;
			used_after  <= used_s1;
		end
	end

endmodule
`default_nettype wire
